/* sv/ibe_pkg.sv */
// ----------------------------------------------------------------------------
// ibe_pkg
// Shared types, command codes and helpers for the indexed blit engine.
// ----------------------------------------------------------------------------
package ibe_pkg;

	// word address width ahead of the capacity check; holds any y * width + x
	localparam int AXW = 23;

	typedef enum logic [2:0] {
		OP_LOAD_SRC  = 3'd0,
		OP_WRITE_DST = 3'd1,
		OP_READ_DST  = 3'd2,
		OP_PASTE     = 3'd3,
		OP_FILL      = 3'd4,
		OP_CLEAR     = 3'd5
	} op_t;

	localparam logic [1:0] REG_DEST_WIDTH  = 2'd0;
	localparam logic [1:0] REG_DEST_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SRC_WIDTH   = 2'd2;
	localparam logic [1:0] REG_SRC_HEIGHT  = 2'd3;

	localparam logic [10:0] RST_WIDTH  = 11'd320;
	localparam logic [10:0] RST_HEIGHT = 11'd200;

	// color key for transparent paste
	localparam logic [7:0] KEY_INDEX = 8'd0;

	// one rectangle scan: two address streams with their own row pitch
	typedef struct packed {
		logic [AXW-1:0] base_a;
		logic [10:0]    stride_a;
		logic [AXW-1:0] base_b;
		logic [10:0]    stride_b;
		logic [10:0]    w;
		logic [10:0]    h;
	} walk_cfg_t;

	typedef struct packed {
		logic           busy;
		logic [AXW-1:0] a;
		logic [AXW-1:0] b;
	} walk_pix_t;

	function automatic logic [10:0] clip_len(logic [10:0] len, logic [10:0] start,
		logic [10:0] limit);
		logic [10:0] room;
		room = limit - start;
		if (start >= limit) begin
			return 11'd0;
		end
		if (len > room) begin
			return room;
		end
		return len;
	endfunction

endpackage

/* sv/indexed_blit_engine.sv */
// ----------------------------------------------------------------------------
// indexed_blit_engine
// 8-bit indexed-pixel blitter with source and destination image stores.
// ----------------------------------------------------------------------------
// One command is worked at a time. After acceptance a setup state clips the
// rectangle and forms the start addresses (one y * width multiply per image),
// then the scanner visits one pixel per cycle, bounded by the single port of
// each store; a paste reads the source store and writes the destination in the
// following cycle. Each command passes through setup and scan; once the scan
// and any paste or read in flight have drained and the output slot is free,
// the result is registered and the engine returns to idle. Clear walks
// dest_width x dest_height words, including those beyond the store capacity,
// which are skipped and flagged in status. The next command is accepted while
// the previous result still waits in the output register. Store contents are
// undefined until written.
// ----------------------------------------------------------------------------
module indexed_blit_engine import ibe_pkg::*; #(
	parameter int STORE_WORDS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [9:0]  dest_x,
	input  logic [9:0]  dest_y,
	input  logic [9:0]  src_x,
	input  logic [9:0]  src_y,
	input  logic [10:0] rect_width,
	input  logic [10:0] rect_height,
	input  logic        transparent,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_pixel,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int AW = $clog2(STORE_WORDS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_RUN
	} state_t;

	state_t         state_q;
	logic           out_valid_q, status_q, st_acc_q;
	logic [7:0]     read_pixel_q, rd_acc_q;

	logic [10:0]    dst_w_q, dst_h_q, src_w_q, src_h_q;
	logic [2:0]     op_q;
	logic [9:0]     dx_q, dy_q, sx_q, sy_q;
	logic [10:0]    rw_q, rh_q;
	logic           transp_q;
	logic [7:0]     value_q;

	walk_cfg_t      wcfg;
	walk_pix_t      pix;
	logic           in_acc, done;

	logic           ok_a, ok_b, hit, src_we, dst_we_s1, paste_go, read_go;
	logic           paste_s2, read_s2, paste_we;
	logic [AW-1:0]  b_s2, dst_addr;
	logic [7:0]     src_rdata, dst_rdata, dst_wdata;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign read_pixel = read_pixel_q;
	assign status     = status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_w_q <= RST_WIDTH;
			dst_h_q <= RST_HEIGHT;
			src_w_q <= RST_WIDTH;
			src_h_q <= RST_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEST_WIDTH:  dst_w_q <= cfg_data;
				REG_DEST_HEIGHT: dst_h_q <= cfg_data;
				REG_SRC_WIDTH:   src_w_q <= cfg_data;
				REG_SRC_HEIGHT:  src_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= op;
			dx_q     <= dest_x;
			dy_q     <= dest_y;
			sx_q     <= src_x;
			sy_q     <= src_y;
			rw_q     <= rect_width;
			rh_q     <= rect_height;
			transp_q <= transparent;
			value_q  <= value;
		end
	end

	// setup: clip and start addresses
	always_comb begin
		wcfg.stride_a = src_w_q;
		wcfg.stride_b = dst_w_q;
		wcfg.base_a   = AXW'(sy_q) * AXW'(src_w_q) + AXW'(sx_q);
		wcfg.base_b   = AXW'(dy_q) * AXW'(dst_w_q) + AXW'(dx_q);
		wcfg.w        = 11'd0;
		wcfg.h        = 11'd0;
		unique case (op_t'(op_q))
			OP_LOAD_SRC, OP_WRITE_DST, OP_READ_DST: begin
				wcfg.w = 11'd1;
				wcfg.h = 11'd1;
			end
			OP_PASTE: begin
				wcfg.w = clip_len(clip_len(rw_q, 11'(sx_q), src_w_q), 11'(dx_q), dst_w_q);
				wcfg.h = clip_len(clip_len(rh_q, 11'(sy_q), src_h_q), 11'(dy_q), dst_h_q);
			end
			OP_FILL: begin
				wcfg.w = clip_len(rw_q, 11'(dx_q), dst_w_q);
				wcfg.h = clip_len(rh_q, 11'(dy_q), dst_h_q);
			end
			OP_CLEAR: begin
				// whole destination as a rectangle from the origin
				wcfg.base_b = '0;
				wcfg.w      = dst_w_q;
				wcfg.h      = dst_h_q;
			end
			default: ;
		endcase
	end

	ibe_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_CALC),
		.cfg    (wcfg),
		.pix    (pix)
	);

	// pixel issue, first stage
	assign ok_a = pix.a < AXW'(STORE_WORDS);
	assign ok_b = pix.b < AXW'(STORE_WORDS);

	always_comb begin
		src_we    = 1'b0;
		dst_we_s1 = 1'b0;
		paste_go  = 1'b0;
		read_go   = 1'b0;
		hit       = 1'b0;
		if (pix.busy) begin
			unique case (op_t'(op_q))
				OP_LOAD_SRC: begin
					src_we = ok_a;
					hit    = !ok_a;
				end
				OP_WRITE_DST, OP_FILL, OP_CLEAR: begin
					dst_we_s1 = ok_b;
					hit       = !ok_b;
				end
				OP_READ_DST: begin
					read_go = ok_b;
					hit     = !ok_b;
				end
				OP_PASTE: begin
					paste_go = ok_a && ok_b;
					hit      = !(ok_a && ok_b);
				end
				default: ;
			endcase
		end
	end

	// second stage: source data back, write destination
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paste_s2 <= 1'b0;
			read_s2  <= 1'b0;
		end else begin
			paste_s2 <= paste_go;
			read_s2  <= read_go;
		end
	end

	always_ff @(posedge clk) begin
		b_s2 <= pix.b[AW-1:0];
	end

	assign paste_we  = paste_s2 && (!transp_q || src_rdata != KEY_INDEX);
	assign dst_addr  = paste_s2 ? b_s2 : pix.b[AW-1:0];
	assign dst_wdata = paste_s2 ? src_rdata : value_q;

	ibe_ram #(.WIDTH(8), .DEPTH(STORE_WORDS)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.addr  (pix.a[AW-1:0]),
		.wdata (value_q),
		.rdata (src_rdata)
	);

	ibe_ram #(.WIDTH(8), .DEPTH(STORE_WORDS)) u_dst_ram (
		.clk   (clk),
		.we    (dst_we_s1 || paste_we),
		.addr  (dst_addr),
		.wdata (dst_wdata),
		.rdata (dst_rdata)
	);

	assign done = !pix.busy && !paste_s2 && !read_s2;

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			read_pixel_q <= 8'd0;
			status_q     <= 1'b0;
			rd_acc_q     <= 8'd0;
			st_acc_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_acc_q <= 8'd0;
						st_acc_q <= 1'b0;
						state_q  <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (hit) begin
						st_acc_q <= 1'b1;
					end
					if (read_s2) begin
						rd_acc_q <= dst_rdata;
					end
					// hold the finished transaction until the output slot frees
					if (done && (!out_valid_q || out_ready)) begin
						out_valid_q  <= 1'b1;
						read_pixel_q <= rd_acc_q;
						status_q     <= st_acc_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/ibe_ram.sv */
// ----------------------------------------------------------------------------
// ibe_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ibe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* sv/ibe_walk.sv */
// ----------------------------------------------------------------------------
// ibe_walk
// Rectangle scanner: steps one pixel per cycle through w x h, producing
// a source-side and a destination-side word address by stride addition.
// ----------------------------------------------------------------------------
module ibe_walk import ibe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  walk_cfg_t cfg,
	output walk_pix_t pix
);

	logic           busy_q;
	logic [AXW-1:0] a_q, b_q, arow_q, brow_q;
	logic [10:0]    xcnt_q, ycnt_q, w_q, sa_q, sb_q;
	logic [AXW-1:0] arow_next, brow_next;

	assign arow_next = arow_q + AXW'(sa_q);
	assign brow_next = brow_q + AXW'(sb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= (cfg.w != 11'd0) && (cfg.h != 11'd0);
		end else if (busy_q && xcnt_q == 11'd0 && ycnt_q == 11'd0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= cfg.base_a;
			arow_q <= cfg.base_a;
			b_q    <= cfg.base_b;
			brow_q <= cfg.base_b;
			xcnt_q <= cfg.w - 11'd1;
			ycnt_q <= cfg.h - 11'd1;
			w_q    <= cfg.w;
			sa_q   <= cfg.stride_a;
			sb_q   <= cfg.stride_b;
		end else if (busy_q) begin
			if (xcnt_q != 11'd0) begin
				xcnt_q <= xcnt_q - 11'd1;
				a_q    <= a_q + AXW'(1);
				b_q    <= b_q + AXW'(1);
			end else if (ycnt_q != 11'd0) begin
				// next row
				ycnt_q <= ycnt_q - 11'd1;
				xcnt_q <= w_q - 11'd1;
				arow_q <= arow_next;
				brow_q <= brow_next;
				a_q    <= arow_next;
				b_q    <= brow_next;
			end
		end
	end

	assign pix = '{busy: busy_q, a: a_q, b: b_q};

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_blit_engine: directed pixel, paste, fill and
// clear commands, then randomized phases over several image geometries with
// idle and backpressure, each result checked against an in-bench image model.
// ----------------------------------------------------------------------------
module tb;
	import ibe_pkg::*;

	localparam int CAPACITY = 65536;
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	// bound on pixels per random fill or paste command, keeps run time sane
	localparam int MAX_AREA = 4096;
	localparam int MAX_CLEAR = 16384;

	typedef struct packed {
		logic [2:0]  op;
		logic [9:0]  dx;
		logic [9:0]  dy;
		logic [9:0]  sx;
		logic [9:0]  sy;
		logic [10:0] rw;
		logic [10:0] rh;
		logic        transp;
		logic [7:0]  val;
	} blit_cmd_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       flag;
	} blit_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic [9:0]  dest_x;
	logic [9:0]  dest_y;
	logic [9:0]  src_x;
	logic [9:0]  src_y;
	logic [10:0] rect_width;
	logic [10:0] rect_height;
	logic        transparent;
	logic [7:0]  value;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_pixel;
	logic        status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	// image model
	logic [7:0] src_img [CAPACITY];
	logic [7:0] dst_img [CAPACITY];
	bit         src_known [CAPACITY];
	bit         dst_known [CAPACITY];
	int         dst_w = 320;
	int         dst_h = 200;
	int         src_w = 320;
	int         src_h = 200;

	blit_result_t readback_q[$];
	int           fails = 0;
	int           items_sent = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;

	indexed_blit_engine #(.STORE_WORDS(CAPACITY)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.src_x      (src_x),
		.src_y      (src_y),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.transparent(transparent),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_pixel (read_pixel),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000000;
		$display("tb: errors");
		$finish;
	end

	initial out_ready <= 1'b0;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin : check_results
		blit_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (readback_q.size() == 0) begin
				$error("unexpected result: read_pixel %0h status %0b", read_pixel, status);
				fails++;
			end else begin
				want = readback_q.pop_front();
				if (read_pixel !== want.pixel) begin
					$error("read_pixel: expected %0h, got %0h", want.pixel, read_pixel);
					fails++;
				end
				if (status !== want.flag) begin
					$error("status: expected %0b, got %0b", want.flag, status);
					fails++;
				end
			end
		end
	end

	function automatic int clip_span(int len, int start, int lim);
		if (start >= lim) begin
			return 0;
		end
		if (len > lim - start) begin
			return lim - start;
		end
		return len;
	endfunction

	function automatic void clip_rect(blit_cmd_t c, output int w, output int h);
		if (c.op == OP_PASTE) begin
			w = clip_span(clip_span(int'(c.rw), int'(c.sx), src_w), int'(c.dx), dst_w);
			h = clip_span(clip_span(int'(c.rh), int'(c.sy), src_h), int'(c.dy), dst_h);
		end else begin
			w = clip_span(int'(c.rw), int'(c.dx), dst_w);
			h = clip_span(int'(c.rh), int'(c.dy), dst_h);
		end
	endfunction

	// updates the image model and returns the result the command must produce
	function automatic blit_result_t predict_blit(blit_cmd_t c);
		blit_result_t r;
		int dx, dy, sx, sy, w, h, a, sa, da;
		dx = int'(c.dx);
		dy = int'(c.dy);
		sx = int'(c.sx);
		sy = int'(c.sy);
		r.pixel = 8'd0;
		r.flag = 1'b0;
		case (c.op)
			OP_LOAD_SRC: begin
				a = sy * src_w + sx;
				if (a < CAPACITY) begin
					src_img[a] = c.val;
					src_known[a] = 1'b1;
				end else begin
					r.flag = 1'b1;
				end
			end
			OP_WRITE_DST: begin
				a = dy * dst_w + dx;
				if (a < CAPACITY) begin
					dst_img[a] = c.val;
					dst_known[a] = 1'b1;
				end else begin
					r.flag = 1'b1;
				end
			end
			OP_READ_DST: begin
				a = dy * dst_w + dx;
				if (a < CAPACITY) r.pixel = dst_img[a];
				else r.flag = 1'b1;
			end
			OP_PASTE: begin
				clip_rect(c, w, h);
				for (int y = 0; y < h; y++) begin
					for (int x = 0; x < w; x++) begin
						sa = (sy + y) * src_w + sx + x;
						da = (dy + y) * dst_w + dx + x;
						if (sa >= CAPACITY || da >= CAPACITY) begin
							r.flag = 1'b1;
						end else if (!c.transp || src_img[sa] != KEY_INDEX) begin
							dst_img[da] = src_img[sa];
							dst_known[da] = 1'b1;
						end
					end
				end
			end
			OP_FILL: begin
				clip_rect(c, w, h);
				for (int y = 0; y < h; y++) begin
					for (int x = 0; x < w; x++) begin
						da = (dy + y) * dst_w + dx + x;
						if (da < CAPACITY) begin
							dst_img[da] = c.val;
							dst_known[da] = 1'b1;
						end else begin
							r.flag = 1'b1;
						end
					end
				end
			end
			OP_CLEAR: begin
				a = dst_w * dst_h;
				if (a > CAPACITY) begin
					a = CAPACITY;
					r.flag = 1'b1;
				end
				for (int i = 0; i < a; i++) begin
					dst_img[i] = c.val;
					dst_known[i] = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// no read of a never-written word, and rectangle work kept bounded
	function automatic bit affordable(blit_cmd_t c);
		int w, h, a, sa;
		if (c.op == OP_READ_DST) begin
			a = int'(c.dy) * dst_w + int'(c.dx);
			return a >= CAPACITY || dst_known[a];
		end
		if (c.op == OP_CLEAR) begin
			return dst_w * dst_h <= MAX_CLEAR;
		end
		if (c.op == OP_FILL || c.op == OP_PASTE) begin
			clip_rect(c, w, h);
			if (w * h > MAX_AREA) begin
				return 1'b0;
			end
		end
		if (c.op == OP_PASTE) begin
			for (int y = 0; y < h; y++) begin
				for (int x = 0; x < w; x++) begin
					sa = (int'(c.sy) + y) * src_w + int'(c.sx) + x;
					if (sa < CAPACITY && !src_known[sa]) begin
						return 1'b0;
					end
				end
			end
		end
		return 1'b1;
	endfunction

	function automatic blit_cmd_t make_cmd(logic [2:0] kind, int dx, int dy, int sx, int sy,
		int rw, int rh, bit transp, int val);
		blit_cmd_t c;
		c.op = kind;
		c.dx = 10'(dx);
		c.dy = 10'(dy);
		c.sx = 10'(sx);
		c.sy = 10'(sy);
		c.rw = 11'(rw);
		c.rh = 11'(rh);
		c.transp = transp;
		c.val = 8'(val);
		return c;
	endfunction

	// edges of the image and of the field are favored
	function automatic logic [9:0] pick_coord(int limit);
		int v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = limit - 1;
			2: v = limit;
			3: v = 1023;
			4, 5: v = int'($urandom_range(0, 1023));
			default: v = (limit > 1) ? int'($urandom_range(0, limit - 1)) : 0;
		endcase
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return v[9:0];
	endfunction

	function automatic logic [10:0] pick_len();
		case ($urandom_range(0, 9))
			0: return 11'd0;
			1: return 11'd1024;
			2: return 11'($urandom_range(0, 1024));
			default: return 11'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 40));
			1: return 1024;
			2: return int'($urandom_range(0, 1024));
			default: return int'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic blit_cmd_t rand_cmd(logic [2:0] kind);
		blit_cmd_t c;
		c.op = kind;
		c.dx = pick_coord(dst_w);
		c.dy = pick_coord(dst_h);
		c.sx = pick_coord(src_w);
		c.sy = pick_coord(src_h);
		c.rw = pick_len();
		c.rh = pick_len();
		c.transp = 1'($urandom_range(0, 1));
		c.val = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic send_cmd(blit_cmd_t c);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= c.op;
		dest_x      <= c.dx;
		dest_y      <= c.dy;
		src_x       <= c.sx;
		src_y       <= c.sy;
		rect_width  <= c.rw;
		rect_height <= c.rh;
		transparent <= c.transp;
		value       <= c.val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		readback_q.push_back(predict_blit(c));
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (readback_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_geometry(int dw, int dh, int sw, int sh);
		settle();
		write_reg(REG_DEST_WIDTH, 11'(dw));
		write_reg(REG_DEST_HEIGHT, 11'(dh));
		write_reg(REG_SRC_WIDTH, 11'(sw));
		write_reg(REG_SRC_HEIGHT, 11'(sh));
		cfg_valid <= 1'b0;
		dst_w = dw & 'h7FF;
		dst_h = dh & 'h7FF;
		src_w = sw & 'h7FF;
		src_h = sh & 'h7FF;
	endtask

	task automatic set_idling(int sender, int receiver);
		idle_pct = sender;
		stall_pct = receiver;
	endtask

	task automatic send_random(logic [2:0] kind);
		blit_cmd_t c;
		int tries;
		for (tries = 0; tries < 8; tries++) begin
			c = rand_cmd(kind);
			if (affordable(c)) break;
		end
		if (!affordable(c)) begin
			c.rw = 11'd0;
			if (c.op == OP_CLEAR) c.op = OP_FILL;
			// the word was never written; store it instead of reading it
			if (c.op == OP_READ_DST) c.op = OP_WRITE_DST;
		end
		send_cmd(c);
	endtask

	// load a small source block, then paste from it
	task automatic load_and_paste();
		blit_cmd_t c;
		int bw, bh, bx, by;
		bw = int'($urandom_range(1, 5));
		bh = int'($urandom_range(1, 5));
		bx = int'(pick_coord(src_w));
		by = int'(pick_coord(src_h));
		if (bx + bw > 1024) bx = 1024 - bw;
		if (by + bh > 1024) by = 1024 - bh;
		for (int y = 0; y < bh; y++) begin
			for (int x = 0; x < bw; x++) begin
				c = rand_cmd(OP_LOAD_SRC);
				c.sx = 10'(bx + x);
				c.sy = 10'(by + y);
				if ($urandom_range(0, 2) == 0) c.val = KEY_INDEX;
				send_cmd(c);
			end
		end
		c = rand_cmd(OP_PASTE);
		c.sx = 10'(bx);
		c.sy = 10'(by);
		c.rw = ($urandom_range(0, 3) == 0) ? 11'd1024 : 11'($urandom_range(0, bw));
		c.rh = ($urandom_range(0, 3) == 0) ? 11'd1024 : 11'($urandom_range(0, bh));
		if (!affordable(c)) begin
			c.rw = 11'(bw);
			c.rh = 11'(bh);
		end
		send_cmd(c);
	endtask

	task automatic write_then_read();
		blit_cmd_t c;
		c = rand_cmd(OP_WRITE_DST);
		send_cmd(c);
		c.op = OP_READ_DST;
		send_cmd(c);
	endtask

	task automatic test_clear();
		// one write under the reset geometry, overwritten by the clears
		send_cmd(make_cmd(OP_WRITE_DST, 319, 199, 0, 0, 0, 0, 0, 'h42));
		set_geometry(1024, 64, 320, 200);
		send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 'h5A));
		// one row past capacity
		set_geometry(1024, 65, 320, 200);
		send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1, 'hA5));
		set_geometry(0, 64, 320, 200);
		send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 'hFF));
		set_geometry(2047, 1, 320, 200);
		send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 'h3C));
	endtask

	task automatic test_pixel_ops();
		set_geometry(1024, 1024, 2, 2);
		send_cmd(make_cmd(OP_LOAD_SRC, 0, 0, 0, 0, 0, 0, 0, 'hFF));
		send_cmd(make_cmd(OP_LOAD_SRC, 0, 0, 1, 0, 0, 0, 0, 'h00));
		send_cmd(make_cmd(OP_LOAD_SRC, 0, 0, 0, 1, 0, 0, 0, 'h81));
		send_cmd(make_cmd(OP_LOAD_SRC, 0, 0, 1, 1, 0, 0, 0, 'h7E));
		// coordinates beyond the image size are used as they stand
		send_cmd(make_cmd(OP_LOAD_SRC, 0, 0, 1023, 1023, 0, 0, 0, 'h55));
		send_cmd(make_cmd(OP_WRITE_DST, 0, 0, 0, 0, 0, 0, 0, 'h00));
		send_cmd(make_cmd(OP_WRITE_DST, 1023, 63, 0, 0, 0, 0, 0, 'hFF));
		send_cmd(make_cmd(OP_WRITE_DST, 1023, 1023, 0, 0, 0, 0, 0, 'hAA));
		send_cmd(make_cmd(OP_READ_DST, 1023, 63, 0, 0, 0, 0, 0, 'h00));
		send_cmd(make_cmd(OP_READ_DST, 0, 64, 0, 0, 0, 0, 0, 'h00));
		send_cmd(rand_cmd(OP_UNUSED_LO));
		send_cmd(rand_cmd(OP_UNUSED_HI));
	endtask

	task automatic test_paste();
		send_cmd(make_cmd(OP_PASTE, 10, 10, 0, 0, 1024, 1024, 0, 'h00));
		// straddles the end of the store; the zero source pixel is keyed out
		send_cmd(make_cmd(OP_PASTE, 1022, 63, 0, 0, 2, 2, 1, 'h00));
		// width clipped by the source offset
		send_cmd(make_cmd(OP_PASTE, 500, 5, 1, 0, 1024, 1, 0, 'h00));
		// start past the source edge: empty
		send_cmd(make_cmd(OP_PASTE, 0, 0, 2, 0, 5, 5, 0, 'h00));
		send_cmd(make_cmd(OP_READ_DST, 1023, 63, 0, 0, 0, 0, 0, 'h00));
		send_cmd(make_cmd(OP_READ_DST, 10, 11, 0, 0, 0, 0, 0, 'h00));
	endtask

	task automatic test_fill();
		send_cmd(make_cmd(OP_FILL, 1000, 60, 0, 0, 1024, 1024, 0, 'h3C));
		send_cmd(make_cmd(OP_FILL, 5, 5, 0, 0, 0, 7, 0, 'h11));
	endtask

	task automatic test_random();
		int quota;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_geometry(320, 200, 320, 200);
				1: set_geometry(1024, 64, 16, 16);
				2: set_geometry(64, 1024, 1024, 1024);
				3: set_geometry(2047, 31, 0, 0);
				4: set_geometry(1, 1024, 2047, 1);
				5: set_geometry(0, 0, 8, 8);
				default: set_geometry(pick_dim(), pick_dim(), pick_dim(), pick_dim());
			endcase
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(49, 0);
				2: set_idling(0, 49);
				default: set_idling(6, 6);
			endcase
			quota = items_sent + 140;
			while (items_sent < quota) begin
				case ($urandom_range(0, 15))
					0, 1, 2, 3: load_and_paste();
					4, 5: send_random(OP_WRITE_DST);
					6, 7: send_random(OP_READ_DST);
					8: send_random(OP_LOAD_SRC);
					9, 10: send_random(OP_FILL);
					11: send_random(OP_PASTE);
					12: send_random(OP_CLEAR);
					13: send_random($urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI);
					default: write_then_read();
				endcase
			end
		end
		set_idling(0, 0);
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		op          <= 3'd0;
		dest_x      <= 10'd0;
		dest_y      <= 10'd0;
		src_x       <= 10'd0;
		src_y       <= 10'd0;
		rect_width  <= 11'd0;
		rect_height <= 11'd0;
		transparent <= 1'b0;
		value       <= 8'd0;
		cfg_valid   <= 1'b0;
		cfg_index   <= 2'd0;
		cfg_data    <= 11'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clear();
		test_pixel_ops();
		test_paste();
		test_fill();
		test_random();
		settle();
		repeat (50) @(posedge clk);
		if (fails == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
